// ===== rtl/vasf_pkg.sv =====
// Shared types and constants of the vorticity angle selective filter.
`default_nettype none
package vasf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int QDEPTH      = 2;

  localparam logic REG_SINE_THRESH = 1'b0;
  localparam logic REG_NOISE_FLOOR = 1'b1;

  localparam logic [15:0] THRESH_RESET = 16'd7666;

  typedef enum logic [1:0] {
    CMD_SKIP,
    CMD_OWN,
    CMD_NEIGH
  } cmd_kind_e;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         axis;
    logic               side;
    logic               present;
    logic signed [31:0] vort_x;
    logic signed [31:0] vort_y;
    logic signed [31:0] vort_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic        zero_structure;
    logic [16:0] sine_squared;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [1:0]       axis;
    logic             side;
    logic             last;
    logic [2:0][31:0] vort;
    logic [2:0][31:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [15:0] thresh;
    logic [31:0] floor;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/vasf_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
`default_nettype none
interface vasf_in_if;
  import vasf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vasf_out_if;
  import vasf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/vorticity_angle_selective_filter_core.sv =====
// Top level of the vorticity angle selective filter: config, front, queue, back.
//
//   channel  dir  handshake         payload
//   in_i     in   valid/ready       in_item_t (one cell entry)
//   out_o    out  valid/ready       out_item_t (one result per cell)
//   cfg      in   cfg_we_i          cfg_idx_i, cfg_data_i
//
// Own-vorticity and ignored entries are handled in the back end's decode state.
// A neighbour entry takes a 32-step square root, then the
// shared 64-step divider for the inverse distance, then three multiplies.
// The last entry adds up to three mean divisions and
// the sine division in the same divider, plus scaling and cross product.
// Async active-low reset; the queue and output register let each side stall.
`default_nettype none
module vorticity_angle_selective_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  vasf_in_if.sink     in_i,
  vasf_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import vasf_pkg::*;

  cfg_t cfg_q;
  logic push, full, q_valid, q_pop;
  cmd_t push_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh <= THRESH_RESET;
      cfg_q.floor  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SINE_THRESH: cfg_q.thresh <= cfg_data_i[15:0];
        REG_NOISE_FLOOR: cfg_q.floor  <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  vasf_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  vasf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  vasf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

// ===== rtl/vasf_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
`default_nettype none
module vasf_front (
  vasf_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output vasf_pkg::cmd_t  item_o
);
  import vasf_pkg::*;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.axis = in_i.payload.axis;
    item_o.side = in_i.payload.side;
    item_o.last = in_i.payload.last_item;
    item_o.vort[0]   = in_i.payload.vort_x;
    item_o.vort[1]   = in_i.payload.vort_y;
    item_o.vort[2]   = in_i.payload.vort_z;
    item_o.offset[0] = in_i.payload.offset_x;
    item_o.offset[1] = in_i.payload.offset_y;
    item_o.offset[2] = in_i.payload.offset_z;
    if (!in_i.payload.opcode) begin
      item_o.kind = CMD_OWN;
    end else if (in_i.payload.present && in_i.payload.axis != 2'd3) begin
      item_o.kind = CMD_NEIGH;
    end else begin
      item_o.kind = CMD_SKIP;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vasf_queue.sv =====
// Command queue between front end and back end.
`default_nettype none
module vasf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vasf_pkg::cmd_t  push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vasf_pkg::cmd_t  item_o
);
  import vasf_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vasf_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module vasf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] n_q, d_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] sh;
  logic        ge;

  assign sh     = {rem_q, n_q[63]};
  assign ge     = (sh >= {1'b0, d_q});
  assign done_o = done_q;
  assign quot_o = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      d_q    <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      n_q    <= dividend_i;
      d_q    <= divisor_i;
      rem_q  <= '0;
      cnt_q  <= 6'd63;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(sh - {1'b0, d_q}) : sh[63:0];
      n_q   <= {n_q[62:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vasf_back.sv =====
// Back end: weight accumulation, mean, norms and squared sine of the angle.
`default_nettype none
module vasf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vasf_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  vasf_pkg::cmd_t  q_item_i,
  output logic            q_pop_o,
  vasf_out_if.source      out_o
);
  import vasf_pkg::*;

  localparam logic [63:0] MEAN_LIM = (VALUE_WIDTH >= 32) ? 64'h7FFF_FFFF
                                     : ((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic [63:0] W_DIVIDEND = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] DEN_LIM    = 64'd1 << 47;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_D2_MUL, S_D2_ACC, S_SQRT, S_WDIV, S_WMUL, S_WACC,
    S_FIN, S_SUM, S_MEAN, S_MDIV, S_NMUL, S_NACC, S_NCHK, S_MAX, S_SCALE,
    S_XMUL, S_XACC, S_SHIFT, S_SDIV, S_OUT
  } state_e;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  state_e       state_q;
  cmd_t         cmd_q;
  logic [31:0]  own_q [3];
  logic [63:0]  sums_q [9];
  logic [47:0]  wsum_q [3];
  logic [5:0]   pres_q;
  logic [1:0]   k_q, a_q;
  logic [2:0]   idx_q;
  logic [3:0]   s_q;
  logic [4:0]   j_q;
  logic [63:0]  acc_q, x_q, r_q;
  logic [31:0]  w_q;
  logic [63:0]  ssum_q [3];
  logic [49:0]  wtot_q;
  logic [31:0]  mean_q [3];
  logic [63:0]  na_q, nb_q, t_q, num_q, den_q;
  logic [31:0]  c_q [3];
  logic [31:0]  mx_q;
  logic [4:0]   rsh_q, lsh_q;
  logic         vsel_q;
  logic [15:0]  sa_q [3];
  logic [15:0]  sb_q [3];
  logic signed [65:0] prod_q;
  logic         out_valid_q;
  out_item_t    out_item_q;
  out_item_t    res_q;

  logic signed [32:0] mul_a, mul_b;
  logic [3:0]   sidx;
  logic [63:0]  sum_rd;
  logic [2:0]   sel;
  logic [63:0]  d2_nx, bit_v, rb, r_nx, x_nx;
  logic         sq_ge;
  logic         div_start, div_done;
  logic [63:0]  div_dvd, div_dvs, div_quot;
  logic [31:0]  vv [3];
  logic [31:0]  mg [3];
  logic [15:0]  sc [3];
  logic [31:0]  mx_init;
  logic [63:0]  mean_qc;
  logic [48:0]  wsum_nx;
  logic [16:0]  sine_nx;
  logic         out_load;

  vasf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign q_pop_o       = (state_q == S_IDLE) && q_valid_i;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;
  assign out_load      = !out_valid_q || out_o.ready;

  always_comb begin
    logic [1:0] base;
    logic       px, py, pz;
    base   = (state_q == S_SUM) ? a_q : cmd_q.axis;
    sidx   = {2'b0, base} * 4'd3 + {2'b0, k_q};
    sum_rd = sums_q[sidx];
    px = &pres_q[1:0];
    py = &pres_q[3:2];
    pz = &pres_q[5:4];
    if (px && py && pz)  sel = 3'b111;
    else if (px && py)   sel = 3'b011;
    else if (px && pz)   sel = 3'b101;
    else if (py && pz)   sel = 3'b110;
    else if (px)         sel = 3'b001;
    else if (py)         sel = 3'b010;
    else if (pz)         sel = 3'b100;
    else                 sel = 3'b000;
  end

  always_comb begin
    d2_nx = acc_q + prod_q[63:0];
    bit_v = 64'd1 << {j_q, 1'b0};
    rb    = r_q + bit_v;
    sq_ge = (x_q >= rb);
    r_nx  = sq_ge ? ((r_q >> 1) + bit_v) : (r_q >> 1);
    x_nx  = sq_ge ? (x_q - rb) : x_q;
    wsum_nx = {1'b0, wsum_q[cmd_q.axis]} + 49'(w_q);
    mean_qc = (div_quot > MEAN_LIM) ? MEAN_LIM : div_quot;
    sine_nx = (div_quot > 64'd65536) ? 17'd65536 : div_quot[16:0];
  end

  always_comb begin
    logic [31:0] scl;
    mx_init = '0;
    for (int k = 0; k < 3; k++) begin
      vv[k] = vsel_q ? own_q[k] : mean_q[k];
      mg[k] = mag32(vv[k]);
      scl   = (mg[k] >> rsh_q) << lsh_q;
      sc[k] = vv[k][31] ? (16'd0 - scl[15:0]) : scl[15:0];
      if (mg[k] > mx_init) mx_init = mg[k];
    end
  end

  always_comb begin
    logic [31:0] m;
    logic [31:0] nv;
    m     = '0;
    nv    = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_D2_MUL: begin
        m     = mag32(cmd_q.offset[k_q]);
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      S_WMUL: begin
        mul_a = {1'b0, w_q};
        mul_b = {cmd_q.vort[k_q][31], cmd_q.vort[k_q]};
      end
      S_NMUL: begin
        nv    = (idx_q < 3'd3) ? own_q[idx_q[1:0]] : mean_q[2'(idx_q - 3'd3)];
        m     = mag32(nv);
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      S_XMUL: begin
        case (s_q)
          4'd0:  begin mul_a = 33'(signed'(sa_q[1])); mul_b = 33'(signed'(sb_q[2])); end
          4'd1:  begin mul_a = 33'(signed'(sa_q[2])); mul_b = 33'(signed'(sb_q[1])); end
          4'd2:  begin mul_a = 33'(signed'(sa_q[2])); mul_b = 33'(signed'(sb_q[0])); end
          4'd3:  begin mul_a = 33'(signed'(sa_q[0])); mul_b = 33'(signed'(sb_q[2])); end
          4'd4:  begin mul_a = 33'(signed'(sa_q[0])); mul_b = 33'(signed'(sb_q[1])); end
          4'd5:  begin mul_a = 33'(signed'(sa_q[1])); mul_b = 33'(signed'(sb_q[0])); end
          4'd6:  begin mul_a = {c_q[0][31], c_q[0]}; mul_b = {c_q[0][31], c_q[0]}; end
          4'd7:  begin mul_a = {c_q[1][31], c_q[1]}; mul_b = {c_q[1][31], c_q[1]}; end
          4'd8:  begin mul_a = {c_q[2][31], c_q[2]}; mul_b = {c_q[2][31], c_q[2]}; end
          4'd9:  begin mul_a = 33'(signed'(sa_q[0])); mul_b = 33'(signed'(sa_q[0])); end
          4'd10: begin mul_a = 33'(signed'(sa_q[1])); mul_b = 33'(signed'(sa_q[1])); end
          4'd11: begin mul_a = 33'(signed'(sa_q[2])); mul_b = 33'(signed'(sa_q[2])); end
          4'd12: begin mul_a = 33'(signed'(sb_q[0])); mul_b = 33'(signed'(sb_q[0])); end
          4'd13: begin mul_a = 33'(signed'(sb_q[1])); mul_b = 33'(signed'(sb_q[1])); end
          4'd14: begin mul_a = 33'(signed'(sb_q[2])); mul_b = 33'(signed'(sb_q[2])); end
          default: begin mul_a = {1'b0, na_q[31:0]}; mul_b = {1'b0, nb_q[31:0]}; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      S_SQRT: begin
        div_start = (j_q == '0);
        div_dvd   = W_DIVIDEND;
        div_dvs   = r_nx;
      end
      S_MEAN: begin
        div_start = (wtot_q != '0);
        div_dvd   = mag64(ssum_q[k_q]);
        div_dvs   = 64'(wtot_q);
      end
      S_SHIFT: begin
        div_start = (den_q < DEN_LIM) && (den_q != '0);
        div_dvd   = num_q << 16;
        div_dvs   = den_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      pres_q      <= '0;
      k_q         <= '0;
      a_q         <= '0;
      idx_q       <= '0;
      s_q         <= '0;
      j_q         <= '0;
      acc_q       <= '0;
      x_q         <= '0;
      r_q         <= '0;
      w_q         <= '0;
      wtot_q      <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      t_q         <= '0;
      num_q       <= '0;
      den_q       <= '0;
      mx_q        <= '0;
      rsh_q       <= '0;
      lsh_q       <= '0;
      vsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      res_q       <= '0;
      for (int i = 0; i < 9; i++) sums_q[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        own_q[i]  <= '0;
        wsum_q[i] <= '0;
        ssum_q[i] <= '0;
        mean_q[i] <= '0;
        c_q[i]    <= '0;
        sa_q[i]   <= '0;
        sb_q[i]   <= '0;
      end
    end else begin
      if (state_q == S_OUT && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cmd_q   <= q_item_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (cmd_q.kind)
            CMD_OWN: begin
              for (int i = 0; i < 3; i++) own_q[i] <= cmd_q.vort[i];
              state_q <= cmd_q.last ? S_FIN : S_IDLE;
            end
            CMD_NEIGH: begin
              k_q     <= '0;
              acc_q   <= '0;
              state_q <= S_D2_MUL;
            end
            default: begin
              state_q <= cmd_q.last ? S_FIN : S_IDLE;
            end
          endcase
        end
        S_D2_MUL: state_q <= S_D2_ACC;
        S_D2_ACC: begin
          acc_q <= d2_nx;
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (d2_nx == '0) begin
              w_q     <= '0;
              state_q <= S_WMUL;
            end else begin
              x_q     <= d2_nx;
              r_q     <= '0;
              j_q     <= 5'd31;
              state_q <= S_SQRT;
            end
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_D2_MUL;
          end
        end
        S_SQRT: begin
          x_q <= x_nx;
          r_q <= r_nx;
          if (j_q == '0) begin
            state_q <= S_WDIV;
          end else begin
            j_q <= j_q - 5'd1;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            w_q     <= (div_quot[63:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
            k_q     <= '0;
            state_q <= S_WMUL;
          end
        end
        S_WMUL: state_q <= S_WACC;
        S_WACC: begin
          sums_q[sidx] <= sat_add(sum_rd, prod_q[63:0]);
          if (k_q == 2'd2) begin
            k_q <= '0;
            wsum_q[cmd_q.axis] <= wsum_nx[48] ? 48'hFFFF_FFFF_FFFF : wsum_nx[47:0];
            pres_q[{cmd_q.axis, cmd_q.side}] <= 1'b1;
            state_q <= cmd_q.last ? S_FIN : S_IDLE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_WMUL;
          end
        end
        S_FIN: begin
          a_q    <= '0;
          k_q    <= '0;
          wtot_q <= '0;
          for (int i = 0; i < 3; i++) ssum_q[i] <= '0;
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (sel[a_q]) begin
            ssum_q[k_q] <= sat_add(ssum_q[k_q], sum_rd);
            if (k_q == '0) begin
              wtot_q <= wtot_q + 50'(wsum_q[a_q]);
            end
          end
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (a_q == 2'd2) begin
              state_q <= S_MEAN;
            end else begin
              a_q <= a_q + 2'd1;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_MEAN: begin
          if (wtot_q == '0) begin
            mean_q[k_q] <= '0;
            if (k_q == 2'd2) begin
              idx_q   <= '0;
              na_q    <= '0;
              nb_q    <= '0;
              state_q <= S_NMUL;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else begin
            state_q <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean_q[k_q] <= ssum_q[k_q][63] ? (32'd0 - mean_qc[31:0]) : mean_qc[31:0];
            if (k_q == 2'd2) begin
              idx_q   <= '0;
              na_q    <= '0;
              nb_q    <= '0;
              state_q <= S_NMUL;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_MEAN;
            end
          end
        end
        S_NMUL: state_q <= S_NACC;
        S_NACC: begin
          if (idx_q < 3'd3) begin
            nb_q <= nb_q + prod_q[63:0];
          end else begin
            na_q <= na_q + prod_q[63:0];
          end
          if (idx_q == 3'd5) begin
            state_q <= S_NCHK;
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= S_NMUL;
          end
        end
        S_NCHK: begin
          if (na_q > {32'd0, cfg_i.floor} && nb_q > {32'd0, cfg_i.floor}) begin
            vsel_q  <= 1'b0;
            state_q <= S_MAX;
          end else begin
            res_q.zero_structure <= 1'b1;
            res_q.sine_squared   <= '0;
            state_q <= S_OUT;
          end
        end
        S_MAX: begin
          mx_q    <= mx_init;
          rsh_q   <= '0;
          lsh_q   <= '0;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          if (mx_q >= 32'h8000) begin
            mx_q  <= mx_q >> 1;
            rsh_q <= rsh_q + 5'd1;
          end else if (mx_q < 32'h4000 && mx_q != '0) begin
            mx_q  <= mx_q << 1;
            lsh_q <= lsh_q + 5'd1;
          end else if (!vsel_q) begin
            for (int i = 0; i < 3; i++) sa_q[i] <= sc[i];
            vsel_q  <= 1'b1;
            state_q <= S_MAX;
          end else begin
            for (int i = 0; i < 3; i++) sb_q[i] <= sc[i];
            s_q     <= '0;
            state_q <= S_XMUL;
          end
        end
        S_XMUL: state_q <= S_XACC;
        S_XACC: begin
          case (s_q) inside
            4'd0, 4'd2, 4'd4: t_q <= prod_q[63:0];
            4'd1:  c_q[0] <= 32'(t_q - prod_q[63:0]);
            4'd3:  c_q[1] <= 32'(t_q - prod_q[63:0]);
            4'd5:  c_q[2] <= 32'(t_q - prod_q[63:0]);
            4'd6:  num_q <= prod_q[63:0];
            4'd7, 4'd8: num_q <= num_q + prod_q[63:0];
            4'd9:  na_q <= prod_q[63:0];
            4'd10, 4'd11: na_q <= na_q + prod_q[63:0];
            4'd12: nb_q <= prod_q[63:0];
            4'd13, 4'd14: nb_q <= nb_q + prod_q[63:0];
            default: den_q <= prod_q[63:0];
          endcase
          if (s_q == 4'd15) begin
            state_q <= S_SHIFT;
          end else begin
            s_q     <= s_q + 4'd1;
            state_q <= S_XMUL;
          end
        end
        S_SHIFT: begin
          if (den_q >= DEN_LIM) begin
            den_q <= den_q >> 1;
            num_q <= num_q >> 1;
          end else if (den_q == '0) begin
            res_q.zero_structure <= 1'b1;
            res_q.sine_squared   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            res_q.sine_squared   <= sine_nx;
            res_q.zero_structure <= (sine_nx <= {1'b0, cfg_i.thresh});
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_item_q <= res_q;
            pres_q     <= '0;
            for (int i = 0; i < 9; i++) sums_q[i] <= '0;
            for (int i = 0; i < 3; i++) begin
              own_q[i]  <= '0;
              wsum_q[i] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
